// File: rtl/core/lprd_pkg.sv
// Shared types and constants of the length-prefixed request deframer.
// Phase codes, byte role and fault codes, field widths and the item/tag records.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package lprd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned ROLE_W  = 3;
	localparam int unsigned ARGN_W  = 23;
	localparam int unsigned FAULT_W = 2;
	localparam int unsigned LEN_W   = 26;   // body length, byte counters
	localparam int unsigned CNT_W   = 24;   // arguments left, up to 2**23 - 1
	localparam int unsigned ACC_W   = 24;   // low three bytes of a 4-byte field
	localparam int unsigned FIELD_W = 32;

	// Largest body length the register can hold; also its reset value
	localparam logic [LEN_W-1:0] MAX_LEN_DEFAULT = LEN_W'(32'd33554432);
	localparam logic [FIELD_W-1:0] FIELD_BYTES = 32'd4;

	typedef enum logic [1:0] {
		PH_LEN,
		PH_COUNT,
		PH_ARGLEN,
		PH_DATA
	} phase_t;

	localparam logic [ROLE_W-1:0] ROLE_MSG_LEN  = 3'd0;
	localparam logic [ROLE_W-1:0] ROLE_ARG_CNT  = 3'd1;
	localparam logic [ROLE_W-1:0] ROLE_ARG_LEN  = 3'd2;
	localparam logic [ROLE_W-1:0] ROLE_ARG_DATA = 3'd3;
	localparam logic [ROLE_W-1:0] ROLE_DISCARD  = 3'd4;

	localparam logic [FAULT_W-1:0] FAULT_NONE      = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_TOO_LONG  = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_MALFORMED = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] stream_byte;
		logic              new_connection;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  byte_value;
		logic [ROLE_W-1:0]  byte_role;
		logic [ARGN_W-1:0]  argument_number;
		logic               argument_end;
		logic               message_done;
		logic [FAULT_W-1:0] fault;
	} tag_t;

endpackage

`default_nettype wire

// File: rtl/core/lprd_in_if.sv
// Input channel of the deframer: one stream byte per transaction.
// Depends on lprd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lprd_in_if;
	logic                        valid;
	logic                        ready;
	logic [lprd_pkg::BYTE_W-1:0] stream_byte;
	logic                        new_connection;

	modport source (output valid, output stream_byte, output new_connection, input ready);
	modport sink (input valid, input stream_byte, input new_connection, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lprd_out_if.sv
// Output channel of the deframer: one tagged byte per transaction.
// Depends on lprd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lprd_out_if;
	logic                         valid;
	logic                         ready;
	logic [lprd_pkg::BYTE_W-1:0]  byte_value;
	logic [lprd_pkg::ROLE_W-1:0]  byte_role;
	logic [lprd_pkg::ARGN_W-1:0]  argument_number;
	logic                         argument_end;
	logic                         message_done;
	logic [lprd_pkg::FAULT_W-1:0] fault;

	modport source (output valid, output byte_value, output byte_role,
		output argument_number, output argument_end, output message_done,
		output fault, input ready);
	modport sink (input valid, input byte_value, input byte_role,
		input argument_number, input argument_end, input message_done,
		input fault, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lprd_in_stage.sv
// Input register stage: holds one accepted byte until the parser consumes it.
// Depends on lprd_pkg and lprd_in_if.
`timescale 1ns / 1ps
`default_nettype none

module lprd_in_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	lprd_in_if.sink              in_ch,
	input  wire logic            out_free,
	output lprd_pkg::item_t      item_s1,
	output logic                 adv
);

	logic valid_s1;

	// Advance into the result register whenever it has room
	assign adv          = valid_s1 & out_free;
	assign in_ch.ready  = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// Payload, loaded on each accepted transaction
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.stream_byte    <= in_ch.stream_byte;
			item_s1.new_connection <= in_ch.new_connection;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/lprd_parser.sv
// Parser state and per-byte tagging logic, plus the max message length register.
// Depends on lprd_pkg. State advances only when a byte moves to the result stage.
`timescale 1ns / 1ps
`default_nettype none

module lprd_parser (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [lprd_pkg::LEN_W-1:0]      cfg_wr_data,
	input  wire logic                            adv,
	input  wire lprd_pkg::item_t                 item_s1,
	output lprd_pkg::tag_t                       tag
);

	localparam int unsigned LW = lprd_pkg::LEN_W;
	localparam int unsigned CW = lprd_pkg::CNT_W;
	localparam int unsigned AW = lprd_pkg::ACC_W;
	localparam int unsigned NW = lprd_pkg::ARGN_W;

	// Registers
	lprd_pkg::phase_t phase_q;
	logic [1:0]       pos_q;
	logic [AW-1:0]    acc_q;
	logic [LW-1:0]    body_q;
	logic [CW-1:0]    args_q;
	logic [NW-1:0]    cur_q;
	logic [LW-1:0]    abl_q;
	logic             closed_q;
	logic [LW-1:0]    max_len_q;

	// State as seen by this byte (after an optional restart)
	lprd_pkg::phase_t st_phase;
	logic [1:0]       st_pos;
	logic [AW-1:0]    st_acc;
	logic [LW-1:0]    st_body;
	logic [CW-1:0]    st_args;
	logic [NW-1:0]    st_cur;
	logic [LW-1:0]    st_abl;
	logic             st_closed;

	// Next state
	lprd_pkg::phase_t phase_n;
	logic [1:0]       pos_n;
	logic [AW-1:0]    acc_n;
	logic [LW-1:0]    body_n;
	logic [CW-1:0]    args_n;
	logic [NW-1:0]    cur_n;
	logic [LW-1:0]    abl_n;
	logic             closed_n;

	logic [7:0]       b;
	logic             nc;
	logic [31:0]      field_val;
	logic             field_last;
	logic [1:0]       pos_inc;
	logic [AW-1:0]    acc_step;
	logic [LW-1:0]    body_dec;
	logic [LW-1:0]    abl_dec;
	logic [CW-1:0]    args_dec;
	logic [NW-1:0]    cur_inc;
	logic [CW-1:0]    args_m1;
	logic [LW-1:0]    need;
	logic [LW-1:0]    room;
	logic             arg_bad;
	logic             fin_done;
	lprd_pkg::phase_t fin_phase;

	assign b  = item_s1.stream_byte;
	assign nc = item_s1.new_connection;

	// New connection clears everything before the byte is looked at
	always_comb begin
		st_phase  = nc ? lprd_pkg::PH_LEN : phase_q;
		st_pos    = nc ? 2'd0 : pos_q;
		st_acc    = nc ? '0 : acc_q;
		st_body   = nc ? '0 : body_q;
		st_args   = nc ? '0 : args_q;
		st_cur    = nc ? '0 : cur_q;
		st_abl    = nc ? '0 : abl_q;
		st_closed = nc ? 1'b0 : closed_q;
	end

	// Field accumulation: little-endian, complete on the fourth byte
	assign field_last = (st_pos == 2'd3);
	assign field_val  = {b, st_acc};
	assign pos_inc    = st_pos + 2'd1;
	assign acc_step   = field_last ? '0 : (st_acc | (AW'(b) << {st_pos, 3'b000}));

	// Saturating down-counters and the argument index increment
	assign body_dec = (st_body != '0) ? st_body - LW'(1) : st_body;
	assign abl_dec  = (st_abl != '0) ? st_abl - LW'(1) : st_abl;
	assign args_dec = (st_args != '0) ? st_args - CW'(1) : st_args;
	assign cur_inc  = st_cur + NW'(1);

	// Room left for this argument once 4 bytes are held for each later one
	assign args_m1 = (st_args != '0) ? st_args - CW'(1) : '0;
	assign need    = {args_m1[LW-3:0], 2'b00};
	assign room    = (body_dec >= need) ? body_dec - need : '0;
	assign arg_bad = (st_args <= CW'(1)) ? (field_val != 32'(body_dec))
	                                     : (field_val > 32'(room));

	// Closing an argument: last one completes the message
	assign fin_done  = (args_dec == '0);
	assign fin_phase = fin_done ? lprd_pkg::PH_LEN : lprd_pkg::PH_ARGLEN;

	// Per-byte tagging and next state
	always_comb begin
		phase_n = st_phase;
		pos_n   = st_pos;
		acc_n   = st_acc;
		body_n  = st_body;
		args_n  = st_args;
		cur_n   = st_cur;
		abl_n   = st_abl;
		tag.byte_value      = b;
		tag.byte_role       = lprd_pkg::ROLE_DISCARD;
		tag.argument_number = '0;
		tag.argument_end    = 1'b0;
		tag.message_done    = 1'b0;
		tag.fault           = lprd_pkg::FAULT_NONE;
		if (!st_closed) begin
			case (st_phase)
				lprd_pkg::PH_COUNT: begin
					tag.byte_role = lprd_pkg::ROLE_ARG_CNT;
					body_n = body_dec;
					pos_n  = pos_inc;
					acc_n  = acc_step;
					if (field_last) begin
						if (field_val == '0) begin
							if (body_dec == '0) begin
								tag.message_done = 1'b1;
								phase_n = lprd_pkg::PH_LEN;
							end else begin
								tag.fault = lprd_pkg::FAULT_MALFORMED;
							end
						end else if (field_val > 32'(body_dec[LW-1:2])) begin
							tag.fault = lprd_pkg::FAULT_MALFORMED;
						end else begin
							args_n  = field_val[CW-1:0];
							cur_n   = '0;
							phase_n = lprd_pkg::PH_ARGLEN;
						end
					end
				end
				lprd_pkg::PH_ARGLEN: begin
					tag.byte_role       = lprd_pkg::ROLE_ARG_LEN;
					tag.argument_number = st_cur;
					body_n = body_dec;
					pos_n  = pos_inc;
					acc_n  = acc_step;
					if (field_last) begin
						if (arg_bad) begin
							tag.fault = lprd_pkg::FAULT_MALFORMED;
						end else if (field_val == '0) begin
							// empty argument ends on its length field
							tag.argument_end = 1'b1;
							tag.message_done = fin_done;
							args_n  = args_dec;
							cur_n   = cur_inc;
							phase_n = fin_phase;
						end else begin
							abl_n   = field_val[LW-1:0];
							phase_n = lprd_pkg::PH_DATA;
						end
					end
				end
				lprd_pkg::PH_DATA: begin
					tag.byte_role       = lprd_pkg::ROLE_ARG_DATA;
					tag.argument_number = st_cur;
					body_n = body_dec;
					abl_n  = abl_dec;
					if (abl_dec == '0) begin
						tag.argument_end = 1'b1;
						tag.message_done = fin_done;
						args_n  = args_dec;
						cur_n   = cur_inc;
						phase_n = fin_phase;
					end
				end
				default: begin
					// message length field
					tag.byte_role = lprd_pkg::ROLE_MSG_LEN;
					phase_n = lprd_pkg::PH_LEN;
					pos_n   = pos_inc;
					acc_n   = acc_step;
					if (field_last) begin
						if (field_val > 32'(max_len_q)) begin
							tag.fault = lprd_pkg::FAULT_TOO_LONG;
						end else if (field_val < lprd_pkg::FIELD_BYTES) begin
							tag.fault = lprd_pkg::FAULT_MALFORMED;
						end else begin
							body_n  = field_val[LW-1:0];
							phase_n = lprd_pkg::PH_COUNT;
						end
					end
				end
			endcase
		end
		closed_n = st_closed | (tag.fault != lprd_pkg::FAULT_NONE);
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lprd_pkg::PH_LEN;
			pos_q    <= 2'd0;
			acc_q    <= '0;
			body_q   <= '0;
			args_q   <= '0;
			cur_q    <= '0;
			abl_q    <= '0;
			closed_q <= 1'b0;
		end else if (adv) begin
			phase_q  <= phase_n;
			pos_q    <= pos_n;
			acc_q    <= acc_n;
			body_q   <= body_n;
			args_q   <= args_n;
			cur_q    <= cur_n;
			abl_q    <= abl_n;
			closed_q <= closed_n;
		end
	end

	// Max message length register, saturating on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= lprd_pkg::MAX_LEN_DEFAULT;
		end else if (cfg_wr_en) begin
			max_len_q <= (cfg_wr_data > lprd_pkg::MAX_LEN_DEFAULT) ?
				lprd_pkg::MAX_LEN_DEFAULT : cfg_wr_data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/lprd_out_stage.sv
// Result register stage: holds one tagged byte until the receiver takes it.
// Depends on lprd_pkg and lprd_out_if.
`timescale 1ns / 1ps
`default_nettype none

module lprd_out_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire lprd_pkg::tag_t  tag,
	lprd_out_if.source           out_ch,
	output logic                 out_free
);

	logic           valid_s2;
	lprd_pkg::tag_t tag_s2;

	// Room for a new result when empty or being drained this cycle
	assign out_free = ~valid_s2 | out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2 <= tag;
		end
	end

	assign out_ch.valid           = valid_s2;
	assign out_ch.byte_value      = tag_s2.byte_value;
	assign out_ch.byte_role       = tag_s2.byte_role;
	assign out_ch.argument_number = tag_s2.argument_number;
	assign out_ch.argument_end    = tag_s2.argument_end;
	assign out_ch.message_done    = tag_s2.message_done;
	assign out_ch.fault           = tag_s2.fault;

endmodule

`default_nettype wire

// File: rtl/core/length_prefixed_request_deframer_unit.sv
// Length-prefixed request deframer, top level.
// Depends on lprd_pkg, lprd_in_if, lprd_out_if, lprd_in_stage, lprd_parser, lprd_out_stage.
//
// Usage:
//   in_ch carries one received byte per transaction, with new_connection set on
//   the first byte of a connection; the parser restarts before that byte.
//   out_ch returns exactly one transaction per input byte, in order: the byte,
//   its role, argument index, argument end / message done flags and fault code.
//   cfg_wr_en / cfg_wr_data write the max message length (values above 32 MiB
//   saturate); write it only while no bytes are in flight.
// Timing:
//   A byte accepted into the input register is tagged by one pass of
//   combinational logic and moves into the result register when that has room,
//   which gives one byte per cycle while out_ch does not stall.
// Reset:
//   arst_n clears both stages, the parser (waiting for a message length) and
//   sets the max message length to 32 MiB.
// Back-pressure:
//   When out_ch stalls, the result register holds and the input register fills;
//   in_ch.ready drops once both are occupied. No byte is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_request_deframer_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	lprd_in_if.sink                          in_ch,
	lprd_out_if.source                       out_ch,
	input  wire logic                        cfg_wr_en,
	input  wire logic [lprd_pkg::LEN_W-1:0]  cfg_wr_data
);

	lprd_pkg::item_t item_s1;
	lprd_pkg::tag_t  tag;
	logic            adv;
	logic            out_free;

	lprd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_free (out_free),
		.item_s1  (item_s1),
		.adv      (adv)
	);

	lprd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.adv         (adv),
		.item_s1     (item_s1),
		.tag         (tag)
	);

	lprd_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.tag      (tag),
		.out_ch   (out_ch),
		.out_free (out_free)
	);

endmodule

`default_nettype wire
